// ----- hdl/uer_pkg.sv -----
`default_nettype none

package uer_pkg;

  localparam int unsigned CountW = 16;

  localparam logic [CountW-1:0] TIMEOUT_RESET  = 16'd500;
  localparam logic [CountW-1:0] COUNT_ALL_ONES = '1;

  // operation codes of an input item
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [1:0] {
    ST_MEASURING = 2'd0,
    ST_DONE      = 2'd1,
    ST_TIMEOUT   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_TRIG_HIGH = 4'b0001,
    PH_TRIG_LOW  = 4'b0010,
    PH_WAIT_RISE = 4'b0100,
    PH_TIME_ECHO = 4'b1000
  } phase_e;

endpackage

`default_nettype wire

// ----- hdl/uer_intf.sv -----
`default_nettype none

interface uer_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic echo_level;

  modport source (output valid, output operation, output echo_level, input ready);
  modport sink   (input valid, input operation, input echo_level, output ready);
endinterface

interface uer_out_if;
  import uer_pkg::*;

  logic              valid;
  logic              ready;
  logic              trigger_level;
  logic [1:0]        status;
  logic [CountW-1:0] tick_count;
  logic              done_event;

  modport source (output valid, output trigger_level, output status, output tick_count,
                  output done_event, input ready);
  modport sink   (input valid, input trigger_level, input status, input tick_count,
                  input done_event, output ready);
endinterface

`default_nettype wire

// ----- hdl/ultrasonic_echo_ranger_core.sv -----
`default_nettype none

// Trigger/echo ranging sequencer. Each input item is either a timer tick carrying the
// sampled echo level or a start command, and each item yields exactly one result item
// with the trigger level, status, tick count and a done pulse. One item is accepted per
// clock unless the result side stalls. An item is taken into the input register when
// accepted, and its result into the result register. Backpressure on the result side stalls
// the input through the ready chain. The user must write the echo_timeout register (reset 500)
// through cfg_we_i/cfg_wdata_i only while no item is in flight; the block does not enforce this.
module ultrasonic_echo_ranger_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  uer_in_if.sink                          in_i,
  uer_out_if.source                       out_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [uer_pkg::CountW-1:0] cfg_wdata_i
);
  import uer_pkg::*;

  // input register
  logic s1_valid_q;
  logic s1_op_q;
  logic s1_echo_q;

  // block state
  logic [CountW-1:0] timeout_q;
  phase_e            phase_q, phase_d;
  status_e           run_status_q, run_status_d;
  logic              echo_now_q, echo_now_d;
  logic              echo_before_q, echo_before_d;
  logic [CountW-1:0] counter_q, counter_d;
  logic              trigger_q, trigger_d;
  logic              done_d;

  // result register
  logic              out_valid_q;
  logic              out_trigger_q;
  status_e           out_status_q;
  logic [CountW-1:0] out_count_q;
  logic              out_done_q;

  logic out_load;
  logic s1_adv;
  logic rise;
  logic fall;

  assign out_load   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_load;
  assign in_i.ready = !s1_valid_q || out_load;

  assign rise = !echo_now_q && s1_echo_q;
  assign fall = echo_now_q && !s1_echo_q;

  always_comb begin
    phase_d       = phase_q;
    run_status_d  = run_status_q;
    echo_now_d    = echo_now_q;
    echo_before_d = echo_before_q;
    counter_d     = counter_q;
    trigger_d     = trigger_q;
    done_d        = 1'b0;
    if (s1_op_q == OP_START) begin
      run_status_d = ST_MEASURING;
    end else begin
      echo_before_d = echo_now_q;
      echo_now_d    = s1_echo_q;
      if (run_status_q == ST_MEASURING) begin
        case (phase_q)
          PH_TRIG_HIGH: begin
            trigger_d = 1'b1;
            phase_d   = PH_TRIG_LOW;
          end
          PH_TRIG_LOW: begin
            trigger_d = 1'b0;
            phase_d   = PH_WAIT_RISE;
            counter_d = '0;
          end
          PH_WAIT_RISE: begin
            if (rise && (counter_q < timeout_q)) begin
              phase_d   = PH_TIME_ECHO;
              counter_d = '0;
            end else if (counter_q > timeout_q) begin
              run_status_d = ST_TIMEOUT;
              phase_d      = PH_TRIG_HIGH;
              counter_d    = COUNT_ALL_ONES;
              done_d       = 1'b1;
            end else begin
              counter_d = counter_q + 1'b1;
            end
          end
          PH_TIME_ECHO: begin
            counter_d = counter_q + 1'b1;
            if (fall) begin
              run_status_d = ST_DONE;
              phase_d      = PH_TRIG_HIGH;
              done_d       = 1'b1;
            end
          end
          default: begin
            phase_d = PH_TRIG_HIGH;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      timeout_q     <= TIMEOUT_RESET;
      phase_q       <= PH_TRIG_HIGH;
      run_status_q  <= ST_DONE;
      echo_now_q    <= 1'b0;
      echo_before_q <= 1'b0;
      counter_q     <= '0;
      trigger_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        phase_q       <= phase_d;
        run_status_q  <= run_status_d;
        echo_now_q    <= echo_now_d;
        echo_before_q <= echo_before_d;
        counter_q     <= counter_d;
        trigger_q     <= trigger_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_op_q   <= in_i.operation;
      s1_echo_q <= in_i.echo_level;
    end
    if (s1_adv) begin
      out_trigger_q <= trigger_d;
      out_status_q  <= run_status_d;
      out_count_q   <= counter_d;
      out_done_q    <= done_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.trigger_level = out_trigger_q;
  assign out_o.status        = out_status_q;
  assign out_o.tick_count    = out_count_q;
  assign out_o.done_event    = out_done_q;

endmodule

`default_nettype wire

// ----- bench/uer_checker.sv -----
`timescale 1ns / 100ps

module uer_checker
  import uer_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  uer_in_if                 in_mon,
  uer_out_if                out_mon,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  typedef struct packed {
    logic              trig;
    status_e           status;
    logic [CountW-1:0] count;
    logic              done;
  } reading_t;

  reading_t          reading_q[$];

  logic [CountW-1:0] timeout_val;
  phase_e            seq_phase;
  status_e           run_state;
  logic              echo_now;
  logic              echo_prev;
  logic [CountW-1:0] width_cnt;
  logic              trig;

  initial fail_count = 0;

  task automatic log_mismatch(input string what, input logic [CountW-1:0] got,
                              input logic [CountW-1:0] want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic range_step(input logic op, input logic echo, output reading_t r);
    logic rise;
    logic fall;
    logic done;
    done = 1'b0;
    if (op == OP_START) begin
      run_state = ST_MEASURING;
    end else begin
      echo_prev = echo_now;
      echo_now  = echo;
      if (run_state == ST_MEASURING) begin
        rise = !echo_prev && echo_now;
        fall = echo_prev && !echo_now;
        case (seq_phase)
          PH_TRIG_HIGH: begin
            trig      = 1'b1;
            seq_phase = PH_TRIG_LOW;
          end
          PH_TRIG_LOW: begin
            trig      = 1'b0;
            seq_phase = PH_WAIT_RISE;
            width_cnt = '0;
          end
          PH_WAIT_RISE: begin
            if (rise && width_cnt < timeout_val) begin
              seq_phase = PH_TIME_ECHO;
              width_cnt = '0;
            end else if (width_cnt > timeout_val) begin
              run_state = ST_TIMEOUT;
              seq_phase = PH_TRIG_HIGH;
              width_cnt = COUNT_ALL_ONES;
              done      = 1'b1;
            end else begin
              width_cnt = width_cnt + 1'b1;
            end
          end
          default: begin
            width_cnt = width_cnt + 1'b1;
            if (fall) begin
              run_state = ST_DONE;
              seq_phase = PH_TRIG_HIGH;
              done      = 1'b1;
            end
          end
        endcase
      end
    end
    r.trig   = trig;
    r.status = run_state;
    r.count  = width_cnt;
    r.done   = done;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    reading_t next_r;
    if (!rst_ni) begin
      timeout_val = TIMEOUT_RESET;
      seq_phase   = PH_TRIG_HIGH;
      run_state   = ST_DONE;
      echo_now    = 1'b0;
      echo_prev   = 1'b0;
      width_cnt   = '0;
      trig        = 1'b0;
      reading_q.delete();
      pending     = 0;
    end else begin
      if (cfg_we_i) begin
        timeout_val = cfg_wdata_i;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (reading_q.size() == 0) begin
          $display("[%0t] result item with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = reading_q.pop_front();
          if (out_mon.trigger_level !== want.trig)
            log_mismatch("trigger_level", CountW'(out_mon.trigger_level),
                         CountW'(want.trig));
          if (out_mon.status !== want.status)
            log_mismatch("status", CountW'(out_mon.status), CountW'(want.status));
          if (out_mon.tick_count !== want.count)
            log_mismatch("tick_count", out_mon.tick_count, want.count);
          if (out_mon.done_event !== want.done)
            log_mismatch("done_event", CountW'(out_mon.done_event), CountW'(want.done));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        range_step(in_mon.operation, in_mon.echo_level, next_r);
        reading_q.push_back(next_r);
      end
      pending = reading_q.size();
    end
  end

endmodule

// ----- bench/ultrasonic_echo_ranger_core_tb.sv -----
`timescale 1ns / 100ps

module ultrasonic_echo_ranger_core_tb;
  import uer_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned EchoTicks  = 30;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [CountW-1:0] cfg_wdata;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       items_sent;
  int unsigned       cycle_cnt;
  bit                idle_on;
  bit                hold_req;

  uer_in_if  in_if ();
  uer_out_if out_if ();

  ultrasonic_echo_ranger_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  uer_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL ultrasonic_echo_ranger_core");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
    end
  end

  task automatic put_item(input logic op, input logic echo);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_if.valid      = 1'b1;
    in_if.operation  = op;
    in_if.echo_level = echo;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic tick(input logic echo);
    put_item(OP_TICK, echo);
  endtask

  task automatic start_cmd();
    put_item(OP_START, 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_timeout(input logic [CountW-1:0] val);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  // start, trigger ticks, quiet wait, echo pulse, fall
  task automatic run_measurement(input int unsigned to);
    int unsigned quiet;
    int unsigned width;
    start_cmd();
    tick(1'($urandom_range(0, 3) == 0));
    tick(1'($urandom_range(0, 3) == 0));
    quiet = $urandom_range(0, (to > 36) ? 40 : to + 3);
    repeat (quiet) tick(1'($urandom_range(0, 11) == 0));
    width = $urandom_range(1, 24);
    repeat (width) begin
      if ($urandom_range(0, 19) == 0) start_cmd();
      tick(1'b1);
    end
    tick(1'b0);
  endtask

  initial begin
    int unsigned to;
    int unsigned target;
    in_if.valid      = 1'b0;
    in_if.operation  = OP_TICK;
    in_if.echo_level = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    rst_ni           = 1'b0;
    idle_on          = 1'b1;
    hold_req         = 1'b0;
    items_sent       = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idle ticks, repeated start, start while timing, two full measurements
    tick(1'b0); tick(1'b1); tick(1'b0);
    start_cmd(); start_cmd();
    tick(1'b1); tick(1'b0); tick(1'b1); tick(1'b1);
    start_cmd();
    tick(1'b1); tick(1'b0);
    start_cmd();
    tick(1'b0); tick(1'b0); tick(1'b0); tick(1'b1); tick(1'b0);

    // rise arriving with an expired count
    set_timeout(16'd1);
    start_cmd();
    tick(1'b0); tick(1'b0); tick(1'b0); tick(1'b0); tick(1'b1);

    // zero timeout never accepts a rise
    set_timeout(16'd0);
    start_cmd();
    tick(1'b0); tick(1'b0); tick(1'b1); tick(1'b1);

    target = items_sent;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: to = 3;
        1: to = 1;
        2: to = $urandom_range(4, 30);
        3: to = 0;
        4: to = 65534;
        default: to = 2;
      endcase
      set_timeout(CountW'(to));
      if (p == 5) idle_on = 1'b0;
      if (p == 2) hold_req = 1'b1;
      target += 75;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 7) begin
          run_measurement(to);
        end else begin
          repeat ($urandom_range(1, 8))
            put_item(1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)));
        end
      end
    end

    // all-ones timeout never expires; the wait lasts until the rise
    set_timeout(16'hFFFF);
    start_cmd();
    tick(1'b0); tick(1'b0);
    repeat (EchoTicks) tick(1'b0);
    repeat (EchoTicks) tick(1'b1);
    tick(1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS ultrasonic_echo_ranger_core");
    end else begin
      $display("FAIL ultrasonic_echo_ranger_core");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/uer_pkg.sv
hdl/uer_intf.sv
hdl/ultrasonic_echo_ranger_core.sv
bench/uer_checker.sv
bench/ultrasonic_echo_ranger_core_tb.sv
